/* rtl/core/tlct_pkg.sv */
// ----------------------------------------------------------------------------
// tlct_pkg
// Shared types and constants for the two-link computed torque unit.
// ----------------------------------------------------------------------------
package tlct_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_INERTIA_A   = 3'd0;
	localparam logic [2:0] REG_INERTIA_B   = 3'd1;
	localparam logic [2:0] REG_COUPLING    = 3'd2;
	localparam logic [2:0] REG_GRAV_SHLDR  = 3'd3;
	localparam logic [2:0] REG_GRAV_ELBOW  = 3'd4;
	localparam logic [2:0] REG_STIFFNESS   = 3'd5;
	localparam logic [2:0] REG_DAMPING     = 3'd6;
	localparam logic [2:0] REG_COMPLIANCE  = 3'd7;

	localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
	localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;
	localparam logic [16:0] POLY_A = 17'd102944;
	localparam logic [16:0] POLY_B = 17'd42048;
	localparam logic [16:0] POLY_C = 17'd4640;

	// configuration snapshot shared by the stages
	typedef struct packed {
		logic [23:0] na;
		logic [23:0] nb;
		logic [23:0] nc;
		logic [23:0] gs;
		logic [23:0] ge;
		logic [63:0] kp;
		logic [63:0] kd;
		logic [63:0] comp;
	} cfg_t;

	// quarter-wave polynomial, Q2.14 result from a 17-bit turn fraction
	function automatic logic signed [17:0] quarter_wave(input logic [16:0] x);
		logic [33:0] x2;
		logic [33:0] t;
		logic [33:0] y;
		begin
			x2 = (34'(x) * 34'(x)) >> 16;
			t = (34'(POLY_C) * x2) >> 16;
			t = 34'(POLY_B) - t;
			t = (t * x2) >> 16;
			t = 34'(POLY_A) - t;
			y = (34'(x) * t) >> 18;
			quarter_wave = 18'(y);
		end
	endfunction

endpackage

/* rtl/core/two_link_computed_torque_sea_unit.sv */
// ----------------------------------------------------------------------------
// two_link_computed_torque_sea_unit
// Computed torque control for a two-link arm with series elastic joints.
// ----------------------------------------------------------------------------
// One transaction enters per cycle; its result passes through the pipeline, whose
// stages are trig index and PD gains, table lookup and acceleration clamp,
// inertia products, mass-times-acceleration and Coriolis, torque sum and
// saturation, compliance product and motor angle saturation. A stall on the
// output holds the whole pipeline; in_stall is the output stall while the
// last stage is full.
module two_link_computed_torque_sea_unit import tlct_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] angle_one,
	input  logic signed [15:0] angle_two,
	input  logic signed [15:0] velocity_one,
	input  logic signed [15:0] velocity_two,
	input  logic signed [15:0] target_one,
	input  logic signed [15:0] target_two,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] torque_one,
	output logic signed [23:0] torque_two,
	output logic signed [15:0] motor_angle_one,
	output logic signed [15:0] motor_angle_two,
	output logic               clipped
);
	cfg_t cfg_q;
	logic en;
	logic [5:0] vld_q;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[5];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INERTIA_A:  cfg_q.na <= cfg_data[23:0];
				REG_INERTIA_B:  cfg_q.nb <= cfg_data[23:0];
				REG_COUPLING:   cfg_q.nc <= cfg_data[23:0];
				REG_GRAV_SHLDR: cfg_q.gs <= cfg_data[23:0];
				REG_GRAV_ELBOW: cfg_q.ge <= cfg_data[23:0];
				REG_STIFFNESS:  cfg_q.kp <= cfg_data;
				REG_DAMPING:    cfg_q.kd <= cfg_data;
				REG_COMPLIANCE: cfg_q.comp <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end

	// stage 1: pd products, trig indexes
	logic signed [16:0] e1, e2;
	logic signed [49:0] pe1_s1, pe2_s1, pd1_s1, pd2_s1;
	logic signed [15:0] w1_s1, w2_s1, r1_s1, r2_s1;
	logic signed [17:0] c2_s2, s2_s2, c1_s2, c12_s2;
	assign e1 = 17'(target_one) - 17'(angle_one);
	assign e2 = 17'(target_two) - 17'(angle_two);

	always_ff @(posedge clk) begin
		if (en) begin
			pe1_s1 <= $signed({1'b0, cfg_q.kp[31:0]}) * e1;
			pe2_s1 <= $signed({1'b0, cfg_q.kp[63:32]}) * e2;
			pd1_s1 <= $signed({1'b0, cfg_q.kd[31:0]}) * velocity_one;
			pd2_s1 <= $signed({1'b0, cfg_q.kd[63:32]}) * velocity_two;
			w1_s1 <= velocity_one;
			w2_s1 <= velocity_two;
			r1_s1 <= target_one;
			r2_s1 <= target_two;
		end
	end

	tlct_trig #(.DEPTH(SINE_TABLE_DEPTH)) u_c2 (.clk(clk), .en(en),
		.angle(17'(angle_two)), .cosine(1'b1), .value(c2_s2));
	tlct_trig #(.DEPTH(SINE_TABLE_DEPTH)) u_s2 (.clk(clk), .en(en),
		.angle(17'(angle_two)), .cosine(1'b0), .value(s2_s2));
	tlct_trig #(.DEPTH(SINE_TABLE_DEPTH)) u_c1 (.clk(clk), .en(en),
		.angle(17'(angle_one)), .cosine(1'b1), .value(c1_s2));
	tlct_trig #(.DEPTH(SINE_TABLE_DEPTH)) u_c12 (.clk(clk), .en(en),
		.angle(17'(angle_one) + 17'(angle_two)), .cosine(1'b1), .value(c12_s2));

	// stage 2: acceleration clamp, velocity products
	logic signed [37:0] v1raw, v2raw;
	logic signed [31:0] v1_s2, v2_s2;
	logic               clip_s2;
	logic signed [15:0] r1_s2, r2_s2;
	logic signed [33:0] cor1_s2, cor2_s2;
	assign v1raw = 38'(pe1_s1 >>> 16) - 38'(pd1_s1 >>> 12);
	assign v2raw = 38'(pe2_s1 >>> 16) - 38'(pd2_s1 >>> 12);

	function automatic logic signed [31:0] clamp32(input logic signed [37:0] x);
		if (x > 38'sh7FFFFFFF) clamp32 = 32'sh7FFFFFFF;
		else if (x < -38'sh80000000) clamp32 = 32'sh80000000;
		else clamp32 = 32'(x);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			v1_s2 <= clamp32(v1raw);
			v2_s2 <= clamp32(v2raw);
			clip_s2 <= (38'(clamp32(v1raw)) != v1raw) || (38'(clamp32(v2raw)) != v2raw);
			cor1_s2 <= 34'(2 * 34'(w1_s1) * 34'(w2_s1)) + 34'(w2_s1) * 34'(w2_s1);
			cor2_s2 <= 34'(w1_s1) * 34'(w1_s1);
			r1_s2 <= r1_s1;
			r2_s2 <= r2_s1;
		end
	end

	// stage 3: coupling inertia products, gravity
	logic signed [27:0] ncc_s3, ncs_s3;
	logic signed [26:0] g1_s3, g12_s3;
	logic signed [31:0] v1_s3, v2_s3;
	logic signed [33:0] cor1_s3, cor2_s3;
	logic signed [15:0] r1_s3, r2_s3;
	logic               clip_s3;
	logic signed [42:0] pncc, pncs, pg1, pg12;
	assign pncc = $signed({1'b0, cfg_q.nc}) * c2_s2;
	assign pncs = $signed({1'b0, cfg_q.nc}) * s2_s2;
	assign pg1  = $signed({1'b0, cfg_q.gs}) * c1_s2;
	assign pg12 = $signed({1'b0, cfg_q.ge}) * c12_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ncc_s3 <= 28'(pncc >>> 14);
			ncs_s3 <= 28'(pncs >>> 14);
			g1_s3 <= 27'(pg1 >>> 16);
			g12_s3 <= 27'(pg12 >>> 16);
			v1_s3 <= v1_s2;
			v2_s3 <= v2_s2;
			cor1_s3 <= cor1_s2;
			cor2_s3 <= cor2_s2;
			r1_s3 <= r1_s2;
			r2_s3 <= r2_s2;
			clip_s3 <= clip_s2;
		end
	end

	// stage 4: M*v and Coriolis products
	logic signed [29:0] m11, m12, m22;
	logic signed [63:0] a11_s4, a12_s4, a21_s4, a22_s4;
	logic signed [63:0] k1_s4, k2_s4;
	logic signed [26:0] g1_s4, g12_s4;
	logic signed [15:0] r1_s4, r2_s4;
	logic               clip_s4;
	assign m12 = 30'(cfg_q.nb) + 30'(ncc_s3);
	assign m11 = 30'(cfg_q.na) + m12 + 30'(ncc_s3);
	assign m22 = 30'(cfg_q.nb);

	always_ff @(posedge clk) begin
		if (en) begin
			a11_s4 <= 64'(m11) * 64'(v1_s3);
			a12_s4 <= 64'(m12) * 64'(v2_s3);
			a21_s4 <= 64'(m12) * 64'(v1_s3);
			a22_s4 <= 64'(m22) * 64'(v2_s3);
			k1_s4 <= 64'(ncs_s3) * 64'(cor1_s3);
			k2_s4 <= 64'(ncs_s3) * 64'(cor2_s3);
			g1_s4 <= g1_s3;
			g12_s4 <= g12_s3;
			r1_s4 <= r1_s3;
			r2_s4 <= r2_s3;
			clip_s4 <= clip_s3;
		end
	end

	// stage 5: torque sum and saturation
	logic signed [47:0] t1raw, t2raw;
	logic signed [23:0] t1_s5, t2_s5;
	logic signed [15:0] r1_s5, r2_s5;
	logic               clip_s5;
	assign t1raw = 48'((a11_s4 + a12_s4) >>> 18) - 48'(k1_s4 >>> 22)
		+ 48'(g1_s4) + 48'(g12_s4);
	assign t2raw = 48'((a21_s4 + a22_s4) >>> 18) + 48'(k2_s4 >>> 22) + 48'(g12_s4);

	function automatic logic signed [23:0] clamp24(input logic signed [47:0] x);
		if (x > 48'sh7FFFFF) clamp24 = 24'sh7FFFFF;
		else if (x < -48'sh800000) clamp24 = 24'sh800000;
		else clamp24 = 24'(x);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s5 <= clamp24(t1raw);
			t2_s5 <= clamp24(t2raw);
			clip_s5 <= clip_s4 || (clamp24(t1raw) != 24'(t1raw))
				|| (clamp24(t2raw) != 24'(t2raw));
			r1_s5 <= r1_s4;
			r2_s5 <= r2_s4;
		end
	end

	// stage 6: motor angle commands
	logic signed [56:0] sp1, sp2;
	logic signed [35:0] ma1, ma2;
	assign sp1 = 57'(t1_s5) * $signed({25'd0, cfg_q.comp[31:0]});
	assign sp2 = 57'(t2_s5) * $signed({25'd0, cfg_q.comp[63:32]});
	assign ma1 = 36'(r1_s5) + 36'(sp1 >>> 22);
	assign ma2 = 36'(r2_s5) + 36'(sp2 >>> 22);

	function automatic logic signed [15:0] clamp16(input logic signed [35:0] x);
		if (x > 36'sh7FFF) clamp16 = 16'sh7FFF;
		else if (x < -36'sh8000) clamp16 = 16'sh8000;
		else clamp16 = 16'(x);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			torque_one <= t1_s5;
			torque_two <= t2_s5;
			motor_angle_one <= clamp16(ma1);
			motor_angle_two <= clamp16(ma2);
			clipped <= clip_s5 || (clamp16(ma1) != 16'(ma1)) || (clamp16(ma2) != 16'(ma2));
		end
	end

	// a stalled result is held in place
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(torque_one))
		else $error("stalled result changed");
	// the input is only stalled by the output
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without cause");
	// an accepted transaction enters the first stage of the valid shift
	assert property (@(posedge clk) disable iff (!arst_n)
		en && in_valid |=> vld_q[0])
		else $error("accepted transaction lost");
endmodule

/* rtl/core/tlct_trig.sv */
// ----------------------------------------------------------------------------
// tlct_trig
// Angle to table index (registered), then registered read of a sine table.
// ----------------------------------------------------------------------------
module tlct_trig import tlct_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [16:0]        angle,
	input  logic                      cosine,
	output logic signed [17:0]        value
);
	localparam int IW = $clog2(DEPTH);

	logic [IW-1:0] idx_s1;
	logic [48:0]   prod;
	logic [31:0]   phase;
	logic signed [17:0] rom_q [DEPTH];

	// turn fraction of the angle
	assign prod  = 49'($signed(angle)) * 49'(INV_TWO_PI_Q32);
	assign phase = prod[43:12] + (cosine ? QUARTER_TURN : 32'd0);

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= phase[31 -: IW];
		end
	end

	// table entry from index
	function automatic logic signed [17:0] entry(input logic [IW-1:0] k);
		logic [IW+17:0] p;
		logic [1:0]     quad;
		logic [16:0]    x;
		logic signed [17:0] y;
		begin
			p = (IW+18)'(k) << (18 - IW);
			quad = p[17:16];
			x = {1'b0, p[15:0]};
			if (quad[0]) begin
				x = 17'h10000 - x;
			end
			y = quarter_wave(x);
			entry = quad[1] ? -y : y;
		end
	endfunction

	// constant table contents, one full turn
	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			rom_q[i] = entry(IW'(i));
		end
	end

	// registered table read
	always_ff @(posedge clk) begin
		if (en) begin
			value <= rom_q[idx_s1];
		end
	end
endmodule
